FILE: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, geometry constants and helpers of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  localparam int unsigned AW = $clog2(CELLS);    // screen address width
  localparam int unsigned CW = $clog2(COLUMNS);  // cursor column width
  localparam int unsigned RW = $clog2(ROWS);     // cursor row width
  localparam int unsigned LW = (AW > 11) ? AW : 11;

  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  CH_NL      = 8'd10;
  localparam logic [7:0]  CH_CR      = 8'd13;
  localparam logic [7:0]  CH_TAB     = 8'd9;
  localparam int unsigned TAB_STOP   = 8;

  typedef enum logic [2:0] {
    OP_PUT_CHAR   = 3'd0,
    OP_WRITE_AT   = 3'd1,
    OP_SET_CURSOR = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_READ_CELL  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCROLL,
    S_BLANK,
    S_FILL,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_code;
    logic [3:0] fore_colour;
    logic [3:0] back_colour;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
  } req_t;

  typedef struct packed {
    logic [10:0] cursor_linear;
    logic [15:0] cell_word;
  } rsp_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  function automatic logic [15:0] make_cell(input logic [7:0] ch,
                                            input logic [3:0] fg,
                                            input logic [3:0] bg);
    return {bg, fg, ch};
  endfunction

endpackage

FILE: rtl/core/tcw_screen_mem.sv
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_mem (
  input  logic              clk_i,
  input  tcw_pkg::mem_req_t mem_i,
  output logic [15:0]       rdata_o
);

  logic [15:0] cells [tcw_pkg::CELLS];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      cells[mem_i.waddr] <= mem_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= cells[mem_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: cursor state, cell writes, scroll/clear sweeps, result.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tcw_pkg::req_t     req_i,
  output tcw_pkg::mem_req_t mem_o,
  input  logic [15:0]       rdata_i,
  output tcw_pkg::rsp_t     rsp_o,
  output logic              rsp_valid_o
);

  localparam int unsigned AW = tcw_pkg::AW;
  localparam int unsigned CW = tcw_pkg::CW;
  localparam int unsigned RW = tcw_pkg::RW;
  localparam int unsigned LW = tcw_pkg::LW;

  tcw_pkg::state_e state_q, state_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic [15:0]     fill_q, fill_d;
  logic            rd_cell_q, rd_cell_d;
  logic [RW-1:0]   row_q, row_d;
  logic [CW-1:0]   col_q, col_d;
  tcw_pkg::rsp_t   rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;

  logic [LW-1:0]   cur_lin;
  logic [LW-1:0]   xy_lin;
  logic            xy_ok;
  logic [CW:0]     col_n;
  logic [RW:0]     row_n;
  logic [15:0]     new_cell;

  assign cur_lin  = LW'(row_q) * LW'(tcw_pkg::COLUMNS) + LW'(col_q);
  assign xy_lin   = LW'(req_i.pos_y) * LW'(tcw_pkg::COLUMNS) + LW'(req_i.pos_x);
  assign xy_ok    = ({1'b0, req_i.pos_x} < 9'(tcw_pkg::COLUMNS)) &&
                    ({1'b0, req_i.pos_y} < 9'(tcw_pkg::ROWS));
  assign new_cell = tcw_pkg::make_cell(req_i.char_code, req_i.fore_colour,
                                       req_i.back_colour);

  // put-char cursor advance, before scroll check
  always_comb begin
    col_n = {1'b0, col_q};
    row_n = {1'b0, row_q};
    if (req_i.char_code == tcw_pkg::CH_NL) begin
      col_n = '0;
      row_n = row_n + (RW+1)'(1);
    end else if (req_i.char_code == tcw_pkg::CH_CR) begin
      col_n = '0;
    end else if (req_i.char_code == tcw_pkg::CH_TAB) begin
      col_n = (col_n + (CW+1)'(tcw_pkg::TAB_STOP)) &
              ~(CW+1)'(tcw_pkg::TAB_STOP - 1);
    end else begin
      col_n = col_n + (CW+1)'(1);
    end
    if (col_n >= (CW+1)'(tcw_pkg::COLUMNS)) begin
      col_n = '0;
      row_n = row_n + (RW+1)'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    rd_cell_d   = rd_cell_q;
    row_d       = row_q;
    col_d       = col_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    mem_o.we    = 1'b0;
    mem_o.waddr = cnt_q;
    mem_o.wdata = fill_q;
    mem_o.raddr = cnt_q;

    case (state_q)
      tcw_pkg::S_INIT: begin
        mem_o.we    = 1'b1;
        mem_o.wdata = tcw_pkg::BLANK_CELL;
        if (cnt_q == AW'(tcw_pkg::CELLS - 1)) begin
          cnt_d   = '0;
          state_d = tcw_pkg::S_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      tcw_pkg::S_IDLE: begin
        if (start) begin
          rd_cell_d = 1'b0;
          state_d   = tcw_pkg::S_RESP;
          case (tcw_pkg::op_e'(req_i.opcode))
            tcw_pkg::OP_PUT_CHAR: begin
              if (req_i.char_code != tcw_pkg::CH_NL &&
                  req_i.char_code != tcw_pkg::CH_CR &&
                  req_i.char_code != tcw_pkg::CH_TAB) begin
                mem_o.we    = 1'b1;
                mem_o.waddr = cur_lin[AW-1:0];
                mem_o.wdata = new_cell;
              end
              if (row_n >= (RW+1)'(tcw_pkg::ROWS)) begin
                row_d   = RW'(tcw_pkg::ROWS - 1);
                col_d   = '0;
                cnt_d   = '0;
                state_d = tcw_pkg::S_SCROLL;
              end else begin
                row_d = row_n[RW-1:0];
                col_d = col_n[CW-1:0];
              end
            end
            tcw_pkg::OP_WRITE_AT: begin
              mem_o.we    = xy_ok;
              mem_o.waddr = xy_lin[AW-1:0];
              mem_o.wdata = new_cell;
            end
            tcw_pkg::OP_SET_CURSOR: begin
              col_d = ({1'b0, req_i.pos_x} >= 9'(tcw_pkg::COLUMNS)) ?
                      CW'(tcw_pkg::COLUMNS - 1) : CW'(req_i.pos_x);
              row_d = ({1'b0, req_i.pos_y} >= 9'(tcw_pkg::ROWS)) ?
                      RW'(tcw_pkg::ROWS - 1) : RW'(req_i.pos_y);
            end
            tcw_pkg::OP_CLEAR: begin
              fill_d  = tcw_pkg::make_cell(tcw_pkg::CH_SPACE, req_i.fore_colour,
                                           req_i.back_colour);
              row_d   = '0;
              col_d   = '0;
              cnt_d   = '0;
              state_d = tcw_pkg::S_FILL;
            end
            tcw_pkg::OP_READ_CELL: begin
              mem_o.raddr = xy_lin[AW-1:0];
              rd_cell_d   = xy_ok;
            end
            default: ;
          endcase
        end
      end

      // copy line below up: read cnt+COLUMNS; write the data read in the cycle before to cnt-1
      tcw_pkg::S_SCROLL: begin
        mem_o.raddr = cnt_q + AW'(tcw_pkg::COLUMNS);
        mem_o.we    = (cnt_q != '0);
        mem_o.waddr = cnt_q - AW'(1);
        mem_o.wdata = rdata_i;
        if (cnt_q == AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS)) begin
          state_d = tcw_pkg::S_BLANK;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      tcw_pkg::S_BLANK: begin
        mem_o.we    = 1'b1;
        mem_o.wdata = tcw_pkg::BLANK_CELL;
        if (cnt_q == AW'(tcw_pkg::CELLS - 1)) begin
          state_d = tcw_pkg::S_RESP;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      tcw_pkg::S_FILL: begin
        mem_o.we = 1'b1;
        if (cnt_q == AW'(tcw_pkg::CELLS - 1)) begin
          state_d = tcw_pkg::S_RESP;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      tcw_pkg::S_RESP: begin
        rsp_d.cursor_linear = cur_lin[10:0];
        rsp_d.cell_word     = rd_cell_q ? rdata_i : 16'h0000;
        rsp_valid_d         = 1'b1;
        state_d             = tcw_pkg::S_IDLE;
      end

      default: state_d = tcw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::S_INIT;
      cnt_q       <= '0;
      rd_cell_q   <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_cell_q   <= rd_cell_d;
      row_q       <= row_d;
      col_q       <= col_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    rsp_q  <= rsp_d;
  end

  assign busy        = (state_q != tcw_pkg::S_IDLE);
  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

FILE: rtl/core/text_console_cell_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit
// Text console engine: screen cell store, cursor and command sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_i) is taken at a rising edge with start high and busy low.
//   Every request yields one result on rsp_o, marked by rsp_valid_o for one
//   cycle; the receiver cannot stall it. The result gives the cursor linear
//   position after the command and, for a read-cell, the addressed cell.
// Timing:
//   Put-char, write-at, set-cursor, read-cell and unused opcodes: the result
//   is formed in S_RESP and its strobe is registered; busy falls in the
//   cycle the strobe rises, and a new request waits until then. The screen
//   memory read data is registered.
//   A put-char that scrolls walks the store one cell per cycle:
//   it copies every row but the top up one line, then blanks the bottom row.
//   Clear fills ROWS*COLUMNS cells, one per cycle.
// Reset:
//   Cursor goes to 0,0, and a clearing pass writes 0x0720 to all 2000
//   cells, one per cycle; busy stays high until it is done.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tcw_pkg::req_t req_i,
  output tcw_pkg::rsp_t rsp_o,
  output logic          rsp_valid_o
);

  tcw_pkg::mem_req_t mem_req;
  logic [15:0]       mem_rdata;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .mem_o       (mem_req),
    .rdata_i     (mem_rdata),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

  tcw_screen_mem u_mem (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule
